FILE: hw/rtl/sma_pkg.sv
// ----------------------------------------------------------------------------
// sma_pkg
// Shared constants for the simple moving average unit: default parameter
// values, fixed field widths and register map.
// ----------------------------------------------------------------------------
package sma_pkg;

  localparam int DEF_MAX_WINDOW  = 256;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int DEF_FRAC_BITS   = 8;

  localparam int AVG_W = 24;
  localparam int LEN_W = 9;

  localparam logic [LEN_W-1:0] LEN_RESET = 9'd4;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index, taken from paddr above the byte offset
  localparam logic REG_WINDOW_LEN = 1'b0;

endpackage

FILE: hw/rtl/sma_if.sv
// ----------------------------------------------------------------------------
// sma_in_if / sma_out_if
// Valid/ready channels carrying sample words in and average words out.
// ----------------------------------------------------------------------------
interface sma_in_if #(
  parameter int SAMPLE_BITS = sma_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          start_series;

  modport source (output valid, output sample, output start_series, input ready);
  modport sink   (input valid, input sample, input start_series, output ready);
endinterface

interface sma_out_if;
  import sma_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [AVG_W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

FILE: hw/rtl/simple_moving_average_unit.sv
// ----------------------------------------------------------------------------
// simple_moving_average_unit
// Moving average over the last window_len samples, exact running sum and a
// bit-serial restoring divider producing the Q15.8 mean.
// Path: an accepted word passes S_UPD, S_PREP, S_DIV and S_FIN into the output
//   register; a word that gives no result goes back to S_IDLE after S_UPD.
// DIV_W = SAMPLE_BITS + clog2(MAX_WINDOW+1) + FRAC_BITS. Words are taken only
//   in S_IDLE; the output register lets the next word in while waiting.
// Reset: sum, fill count, write slot cleared, window_len = 4. Delay line
//   contents are left as they are.
// ----------------------------------------------------------------------------
module simple_moving_average_unit #(
  parameter int MAX_WINDOW  = sma_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = sma_pkg::DEF_SAMPLE_BITS,
  parameter int FRAC_BITS   = sma_pkg::DEF_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  sma_in_if.sink                     in_if,
  sma_out_if.source                  out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sma_pkg::APB_AW-1:0] paddr,
  input  logic [sma_pkg::APB_DW-1:0] pwdata,
  output logic [sma_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import sma_pkg::*;

  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW + 1);
  localparam int DIV_W  = SUM_W + FRAC_BITS;
  localparam int CNT_W  = $clog2(DIV_W + 1);
  localparam int ADR_W  = ((SLOT_W > LEN_W) ? SLOT_W : LEN_W) + 1;
  localparam int RES_W  = ((DIV_W + 1) > AVG_W) ? (DIV_W + 1) : AVG_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_UPD  = 5'b00010,
    S_PREP = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [LEN_W-1:0]          window_len_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic [LEN_W-1:0]          fill_r;
  logic [SLOT_W-1:0]         slot_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                      full_r;
  logic                      sign_r;
  logic [DIV_W-1:0]          quo_r;
  logic [LEN_W-1:0]          rem_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [AVG_W-1:0]   avg_r;
  logic                      out_valid_r;

  logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rd_data_r;

  logic                      cfg_wr;
  logic                      in_acc;
  logic [LEN_W-1:0]          len_eff;
  logic [LEN_W-1:0]          fill_eff;
  logic [ADR_W-1:0]          old_diff;
  logic [SLOT_W-1:0]         old_addr;
  logic                      mem_re;
  logic                      mem_we;
  logic                      emit;
  logic [LEN_W-1:0]          fill_inc;
  logic [SUM_W-1:0]          sum_mag;
  logic [LEN_W:0]            rem_t;
  logic                      rem_ge;
  logic [RES_W-1:0]          mag_ext;
  logic [RES_W-1:0]          res_val;
  logic                      out_load;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_WINDOW_LEN);
  assign prdata = (paddr[2] == REG_WINDOW_LEN) ? APB_DW'(window_len_r) : '0;

  always_comb begin
    if (window_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(window_len_r) > MAX_WINDOW) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = window_len_r;
    end
  end

  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid & in_if.ready;
  assign fill_eff    = in_if.start_series ? '0 : fill_r;

  // slot len words back, modulo the delay line depth
  assign old_diff = ADR_W'(slot_r) - ADR_W'(len_eff);
  assign old_addr = old_diff[ADR_W-1] ? SLOT_W'(old_diff + ADR_W'(MAX_WINDOW))
                                      : SLOT_W'(old_diff);

  assign mem_re   = in_acc && (fill_eff >= len_eff);
  assign mem_we   = (state_r == S_UPD);
  assign fill_inc = fill_r + LEN_W'(1);
  assign emit     = full_r || (fill_inc == len_eff);

  assign sum_mag  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  assign rem_t    = {rem_r, quo_r[DIV_W-1]};
  assign rem_ge   = rem_t >= (LEN_W + 1)'(len_eff);

  assign mag_ext  = RES_W'(quo_r);
  assign res_val  = sign_r ? (~mag_ext + RES_W'(1)) : mag_ext;
  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_if.ready);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot_r] <= sample_r;
    end
    if (mem_re) begin
      rd_data_r <= mem[old_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        state_nxt = emit ? S_PREP : S_IDLE;
      end
      S_PREP: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      window_len_r <= LEN_RESET;
      sum_r        <= '0;
      fill_r       <= '0;
      slot_r       <= '0;
      full_r       <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            sample_r <= in_if.sample;
            full_r   <= (fill_eff >= len_eff);
            if (in_if.start_series) begin
              sum_r  <= '0;
              fill_r <= '0;
            end
          end
        end
        S_UPD: begin
          if (full_r) begin
            sum_r <= sum_r + SUM_W'(sample_r) - SUM_W'(rd_data_r);
          end else begin
            sum_r  <= sum_r + SUM_W'(sample_r);
            fill_r <= fill_inc;
          end
          slot_r <= (slot_r == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);
        end
        S_PREP: begin
          sign_r <= sum_r[SUM_W-1];
          quo_r  <= DIV_W'(sum_mag) << FRAC_BITS;
          rem_r  <= '0;
          cnt_r  <= CNT_W'(DIV_W);
        end
        S_DIV: begin
          rem_r <= rem_ge ? LEN_W'(rem_t - (LEN_W + 1)'(len_eff)) : LEN_W'(rem_t);
          quo_r <= {quo_r[DIV_W-2:0], rem_ge};
          cnt_r <= cnt_r - CNT_W'(1);
        end
        S_FIN: begin
        end
        default: begin
        end
      endcase

      if (out_load) begin
        avg_r       <= res_val[AVG_W-1:0];
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_wr) begin
        window_len_r <= pwdata[LEN_W-1:0];
        sum_r        <= '0;
        fill_r       <= '0;
      end
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.average = avg_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= len_eff)
    else $error("fill count above window length");

  a_accept_upd: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_UPD)
    else $error("accepted word not taken into update");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> cnt_r != '0)
    else $error("divider running with zero count");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == S_IDLE)
    else $error("result word not presented");

endmodule

FILE: sim/simple_moving_average_unit_tb.sv
// ----------------------------------------------------------------------------
// simple_moving_average_unit_tb
// Drives sample words through the moving average unit under a range of
// window lengths, takes each Q15.8 average from the directed table or the
// bench model and checks every output word in order. Both channels idle at
// random; window_len is only changed once the unit has drained.
// ----------------------------------------------------------------------------
module simple_moving_average_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sma_pkg::*;

  localparam int WIN_MAX  = DEF_MAX_WINDOW;
  localparam int IDLE_PCT = 32;
  localparam int SETTLE   = 60;

  typedef enum logic [1:0] {ROW_NONE, ROW_VALUE, ROW_MODEL} row_kind_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               start;
    row_kind_t          kind;
    logic [AVG_W-1:0]   avg;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  sma_in_if #(.SAMPLE_BITS(DEF_SAMPLE_BITS)) in_ch ();
  sma_out_if out_ch ();

  simple_moving_average_unit u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // bench copy of the averaging state
  logic signed [15:0] line_mem [WIN_MAX];
  longint             win_sum;
  int unsigned        fill_cnt;
  int unsigned        wr_slot;
  logic [LEN_W-1:0]   win_len;

  logic [AVG_W-1:0] avg_q [$];
  int               err_cnt;
  bit               calm;
  int               stall_req;

  task automatic sma_predict(input logic signed [15:0] s, input logic st,
                             output bit got, output logic [AVG_W-1:0] avg);
    int unsigned n;
    int unsigned old;
    longint      q;
    n = (win_len == 0) ? 1 : ((win_len > WIN_MAX) ? WIN_MAX : int'(win_len));
    if (st) begin
      win_sum  = 0;
      fill_cnt = 0;
    end
    if (fill_cnt < n) begin
      win_sum  += s;
      fill_cnt++;
    end else begin
      old = (wr_slot + WIN_MAX - n) % WIN_MAX;
      win_sum += longint'(s) - longint'(line_mem[old]);
    end
    line_mem[wr_slot] = s;
    wr_slot = (wr_slot + 1) % WIN_MAX;
    got = (fill_cnt >= n);
    q   = (win_sum * 256) / longint'(n);
    avg = got ? q[AVG_W-1:0] : '0;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic signed [15:0] s, input logic st,
                           input row_kind_t kind, input logic [AVG_W-1:0] typed);
    bit               got;
    logic [AVG_W-1:0] avg;
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample       <= s;
    in_ch.start_series <= st;
    do @(posedge clk); while (!in_ch.ready);
    sma_predict(s, st, got, avg);
    if (kind == ROW_VALUE) avg_q.push_back(typed);
    else if (kind == ROW_MODEL && got) avg_q.push_back(avg);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (avg_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [LEN_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_WINDOW_LEN, 2'b00};
    pwdata  <= APB_DW'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    win_len  = v;
    win_sum  = 0;
    fill_cnt = 0;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic cfg_check(input logic [LEN_W-1:0] want);
    logic [APB_DW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_WINDOW_LEN, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    if (rd[LEN_W-1:0] !== want) begin
      $error("window_len: expected %0d, actual %0d", want, rd[LEN_W-1:0]);
      err_cnt++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample();
    unique case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'($urandom_range(15)) - 16'sd8;
      default: return 16'($urandom());
    endcase
  endfunction

  // directed words, window_len at its reset value of 4
  stim_row_t dir_tab [21] = '{
    '{16'sh7FFF, 1'b1, ROW_NONE,  24'h000000},
    '{16'sh7FFF, 1'b0, ROW_NONE,  24'h000000},
    '{16'sh7FFF, 1'b0, ROW_NONE,  24'h000000},
    '{16'sh7FFF, 1'b0, ROW_VALUE, 24'h7FFF00},
    '{16'sh7FFF, 1'b0, ROW_VALUE, 24'h7FFF00},
    '{16'sh8000, 1'b0, ROW_MODEL, 24'h000000},
    '{16'sh8000, 1'b0, ROW_MODEL, 24'h000000},
    '{16'sh8000, 1'b0, ROW_MODEL, 24'h000000},
    '{16'sh8000, 1'b0, ROW_VALUE, 24'h800000},
    '{16'sh0000, 1'b1, ROW_NONE,  24'h000000},
    '{16'sh0000, 1'b0, ROW_NONE,  24'h000000},
    '{16'sh0000, 1'b0, ROW_NONE,  24'h000000},
    '{16'sh0000, 1'b0, ROW_VALUE, 24'h000000},
    '{16'sh0001, 1'b0, ROW_MODEL, 24'h000000},
    '{16'shFFFF, 1'b0, ROW_MODEL, 24'h000000},
    '{16'shFFFD, 1'b0, ROW_MODEL, 24'h000000},
    '{16'sh0005, 1'b1, ROW_NONE,  24'h000000},
    '{16'sh0005, 1'b1, ROW_NONE,  24'h000000},
    '{16'shFFF9, 1'b0, ROW_NONE,  24'h000000},
    '{16'sh0064, 1'b0, ROW_NONE,  24'h000000},
    '{16'shFF38, 1'b0, ROW_MODEL, 24'h000000}
  };

  int          phase_len [10] = '{1, 0, 2, 3, 7, 256, 300, 511, 16, -1};
  int          phase_cnt [10] = '{120, 100, 120, 150, 150, 400, 300, 300, 80, 80};

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (avg_q.size() == 0) begin
        $error("average: expected none, actual %0d", out_ch.average);
        err_cnt++;
      end else if (out_ch.average !== avg_q[0]) begin
        $error("average: expected %0d, actual %0d",
               $signed(avg_q[0]), out_ch.average);
        err_cnt++;
        void'(avg_q.pop_front());
      end else begin
        void'(avg_q.pop_front());
      end
    end
  end

  initial begin
    int hold_left;
    int seen;
    hold_left    = 0;
    seen         = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req != seen) begin
        seen      = stall_req;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(99) < IDLE_PCT) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("simple_moving_average_unit test failed");
    $finish;
  end

  initial begin
    int               n;
    int               left;
    logic [LEN_W-1:0] v;
    logic             st;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.sample       = '0;
    in_ch.start_series = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    err_cnt            = 0;
    calm               = 1'b0;
    stall_req          = 0;
    win_sum            = 0;
    fill_cnt           = 0;
    wr_slot            = 0;
    win_len            = LEN_RESET;
    foreach (line_mem[i]) line_mem[i] = '0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    cfg_check(LEN_RESET);
    foreach (dir_tab[i])
      send_word(dir_tab[i].sample, dir_tab[i].start, dir_tab[i].kind, dir_tab[i].avg);
    drain();

    for (int p = 0; p < 10; p++) begin
      v = (phase_len[p] < 0) ? LEN_W'($urandom_range(1, 40)) : LEN_W'(phase_len[p]);
      cfg_write(v);
      cfg_check(v);
      n    = (v == 0) ? 1 : ((v > WIN_MAX) ? WIN_MAX : int'(v));
      calm = (p == 2);
      left = 0;
      for (int k = 0; k < phase_cnt[p]; k++) begin
        if (p == 3 && k == 30) stall_req++;
        if (p == 4 && k == 75) begin
          in_ch.valid <= 1'b0;
          while (avg_q.size() != 0) @(negedge clk);
          @(negedge clk);
        end
        st = 1'b0;
        if (left == 0) begin
          st   = 1'b1;
          left = ($urandom_range(9) == 0) ? $urandom_range(1, n)
                                          : n + $urandom_range(0, 3 * n + 20);
        end
        left--;
        send_word(pick_sample(), st, ROW_MODEL, '0);
      end
      calm = 1'b0;
      drain();
    end

    if (err_cnt == 0) begin
      $display("simple_moving_average_unit test passed");
    end else begin
      $display("simple_moving_average_unit test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/sma_pkg.sv
hw/rtl/sma_if.sv
hw/rtl/simple_moving_average_unit.sv
sim/simple_moving_average_unit_tb.sv
